>>> rtl/core/cicfv_pkg.sv
// ----------------------------------------------------------------------------
// cicfv_pkg
// shared types, constants and saturating helpers of the cicsam face value unit
// ----------------------------------------------------------------------------
`default_nettype none

package cicfv_pkg;

	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int MUL_DEPTH        = 3;

	typedef logic signed [63:0] val_t;

	localparam val_t IMAX = 64'sh3FFF_FFFF_FFFF_FFFF;

	localparam logic [0:0] REG_COURANT_SCALE = 1'b0;

	function automatic val_t sat_wide(input logic signed [64:0] v);
		logic signed [64:0] lim;
		lim = 65'(IMAX);
		if (v > lim)
			return IMAX;
		else if (v < -lim)
			return -IMAX;
		else
			return val_t'(v[63:0]);
	endfunction

	function automatic val_t add_s(input val_t a, input val_t b);
		return sat_wide(65'(a) + 65'(b));
	endfunction

	function automatic val_t sub_s(input val_t a, input val_t b);
		return sat_wide(65'(a) - 65'(b));
	endfunction

	function automatic logic [63:0] mag(input val_t v);
		val_t n;
		n = -v;
		return v[63] ? n[63:0] : v[63:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/cicfv_in_if.sv
// ----------------------------------------------------------------------------
// cicfv_in_if
// request channel carrying one cell face stencil
// ----------------------------------------------------------------------------
`default_nettype none

interface cicfv_in_if #(
	parameter int SAMPLE_WIDTH = cicfv_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     direction;
	logic signed [SAMPLE_WIDTH-1:0] center_value;
	logic signed [SAMPLE_WIDTH-1:0] upstream_value;
	logic signed [SAMPLE_WIDTH-1:0] downstream_value;
	logic signed [SAMPLE_WIDTH-1:0] velocity_first;
	logic signed [SAMPLE_WIDTH-1:0] velocity_second;
	logic signed [SAMPLE_WIDTH-1:0] diff_x;
	logic signed [SAMPLE_WIDTH-1:0] diff_y;
	logic signed [SAMPLE_WIDTH-1:0] diff_z;

	modport source (
		output valid, direction, center_value, upstream_value, downstream_value,
		output velocity_first, velocity_second, diff_x, diff_y, diff_z,
		input  ready
	);

	modport sink (
		input  valid, direction, center_value, upstream_value, downstream_value,
		input  velocity_first, velocity_second, diff_x, diff_y, diff_z,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/cicfv_out_if.sv
// ----------------------------------------------------------------------------
// cicfv_out_if
// result channel carrying one face value
// ----------------------------------------------------------------------------
`default_nettype none

interface cicfv_out_if #(
	parameter int SAMPLE_WIDTH = cicfv_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] face_value;

	modport source (output valid, face_value, input ready);
	modport sink (input valid, face_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cicsam_face_value_unit.sv
// ----------------------------------------------------------------------------
// cicsam_face_value_unit
// cicsam face value of a volume-fraction field for one cell face per request
// ----------------------------------------------------------------------------
// datapath: three chained one-bit-per-stage dividers plus four multipliers
// throughput: one request per cycle while the skid stage is empty; a stalled result parks in a skid stage
// reset: arst_n clears all valid bits and courant_scale to zero
`default_nettype none

module cicsam_face_value_unit #(
	parameter int SAMPLE_WIDTH = cicfv_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = cicfv_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	cicfv_in_if.sink         in_ch,
	cicfv_out_if.source      out_ch
);

	typedef cicfv_pkg::val_t val_t;

	localparam int   DIV_DEPTH = 64 + FRAC_BITS + 1;
	localparam int   MUL_DEPTH = cicfv_pkg::MUL_DEPTH;
	localparam int   GSHIFT    = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH - 32 : 0;
	localparam val_t ONE       = 64'sd1 <<< FRAC_BITS;
	localparam val_t SMAX      = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam val_t SMIN      = -SMAX - 64'sd1;

	typedef struct packed {
		val_t             num1;
		val_t             den1;
		logic [2:0][63:0] sq;
		logic [1:0]       dir;
		val_t             cc;
		val_t             cd;
	} side_a_t;

	typedef struct packed {
		val_t co;
		val_t cc;
		val_t cd;
		logic gok;
	} side_b_t;

	typedef struct packed {
		val_t ccn;
		val_t gamma;
		val_t co;
		val_t cc;
		val_t cd;
		logic inr;
	} side_c_t;

	typedef struct packed {
		val_t sum;
		val_t ccn;
		val_t gamma;
		val_t cc;
		val_t cd;
		logic inr;
	} side_d_t;

	typedef struct packed {
		val_t ccn;
		val_t cc;
		val_t cd;
	} side_e_t;

	typedef struct packed {
		val_t cc;
		val_t cd;
	} side_f_t;

	// configuration
	logic [31:0] courant_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == cicfv_pkg::REG_COURANT_SCALE) ? courant_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			courant_q <= 32'd0;
		else if (psel && penable && pwrite && pready
			&& paddr[2] == cicfv_pkg::REG_COURANT_SCALE)
			courant_q <= pwdata;
	end

	// flow control
	logic en;
	logic out_v_q, skid_v_q;
	logic signed [SAMPLE_WIDTH-1:0] out_d_q, skid_d_q;

	assign en          = !skid_v_q;
	assign in_ch.ready = en;

	// stage 1: request capture
	logic                           v_s1;
	logic [1:0]                     dir_s1;
	logic signed [SAMPLE_WIDTH-1:0] cc_s1, cu_s1, cd_s1, v1_s1, v2_s1;
	logic signed [SAMPLE_WIDTH-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s1 <= in_ch.direction;
			cc_s1  <= in_ch.center_value;
			cu_s1  <= in_ch.upstream_value;
			cd_s1  <= in_ch.downstream_value;
			v1_s1  <= in_ch.velocity_first;
			v2_s1  <= in_ch.velocity_second;
			dx_s1  <= in_ch.diff_x;
			dy_s1  <= in_ch.diff_y;
			dz_s1  <= in_ch.diff_z;
		end
	end

	// stage 2: differences, velocity mean, gradient squares
	logic    v_s2;
	val_t    mean_s2;
	side_a_t sa_s2;
	val_t    cc_x, cu_x, cd_x, vsum;
	logic [63:0] dm [3];
	logic [63:0] ds [3];

	always_comb begin
		cc_x  = val_t'(cc_s1);
		cu_x  = val_t'(cu_s1);
		cd_x  = val_t'(cd_s1);
		vsum  = val_t'(v1_s1) + val_t'(v2_s1);
		dm[0] = cicfv_pkg::mag(val_t'(dx_s1));
		dm[1] = cicfv_pkg::mag(val_t'(dy_s1));
		dm[2] = cicfv_pkg::mag(val_t'(dz_s1));
		for (int n = 0; n < 3; n++)
			ds[n] = dm[n] >> GSHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mean_s2    <= (vsum + val_t'({63'b0, vsum[63]})) >>> 1;
			sa_s2.num1 <= cicfv_pkg::sub_s(cc_x, cu_x);
			sa_s2.den1 <= cicfv_pkg::sub_s(cd_x, cu_x);
			for (int n = 0; n < 3; n++)
				sa_s2.sq[n] <= {32'b0, ds[n][31:0]} * {32'b0, ds[n][31:0]};
			sa_s2.dir  <= dir_s1;
			sa_s2.cc   <= cc_x;
			sa_s2.cd   <= cd_x;
		end
	end

	// courant product
	logic    va;
	val_t    mula_a [1], mula_b [1], mula_p [1];
	side_a_t sa_d;

	assign mula_a[0] = mean_s2;
	assign mula_b[0] = val_t'({32'b0, courant_q});

	cicfv_mul #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_mul_co (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s2),
		.a(mula_a), .b(mula_b), .vout(va), .p(mula_p)
	);

	cicfv_delay #(.WIDTH($bits(side_a_t)), .DEPTH(MUL_DEPTH)) u_dl_a (
		.clk(clk), .en(en), .din(sa_s2), .dout(sa_d)
	);

	// stage 3: divider operands for normalized value and gamma
	logic        v_s3;
	logic [63:0] dan_s3 [2], dad_s3 [2];
	logic [1:0]  daneg_s3;
	side_b_t     sb_s3;
	logic [63:0] gsum, g2;

	always_comb begin
		gsum = sa_d.sq[0] + sa_d.sq[1] + sa_d.sq[2];
		case (sa_d.dir)
			2'd0:    g2 = sa_d.sq[0];
			2'd1:    g2 = sa_d.sq[1];
			2'd2:    g2 = sa_d.sq[2];
			default: g2 = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= va;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dan_s3[0]   <= cicfv_pkg::mag(sa_d.num1);
			dad_s3[0]   <= cicfv_pkg::mag(sa_d.den1);
			daneg_s3[0] <= sa_d.num1[63] ^ sa_d.den1[63];
			dan_s3[1]   <= g2;
			dad_s3[1]   <= gsum;
			daneg_s3[1] <= 1'b0;
			sb_s3.co    <= val_t'(cicfv_pkg::mag(mula_p[0]));
			sb_s3.cc    <= sa_d.cc;
			sb_s3.cd    <= sa_d.cd;
			sb_s3.gok   <= (sa_d.dir != 2'd3) && (gsum != 64'd0);
		end
	end

	logic    vda;
	val_t    da_q [2];
	side_b_t sb_d;

	cicfv_div #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_div_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s3),
		.num(dan_s3), .den(dad_s3), .neg(daneg_s3), .vout(vda), .quo(da_q)
	);

	cicfv_delay #(.WIDTH($bits(side_b_t)), .DEPTH(DIV_DEPTH)) u_dl_b (
		.clk(clk), .en(en), .din(sb_s3), .dout(sb_d)
	);

	// stage 4: gamma, quickest operands
	logic    v_s4;
	val_t    ccn_s4, gamma_s4, co_s4, omc_s4, six_s4, cc_s4, cd_s4;
	logic    inr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= vda;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ccn_s4   <= da_q[0];
			if (!sb_d.gok)
				gamma_s4 <= 64'sd0;
			else
				gamma_s4 <= (da_q[1] > ONE) ? ONE : da_q[1];
			co_s4    <= sb_d.co;
			omc_s4   <= cicfv_pkg::sub_s(ONE, sb_d.co);
			six_s4   <= da_q[0] * 64'sd6 + 64'sd3 * ONE;
			cc_s4    <= sb_d.cc;
			cd_s4    <= sb_d.cd;
			inr_s4   <= !da_q[0][63] && (da_q[0] < ONE);
		end
	end

	logic    vtu;
	val_t    multu_a [2], multu_b [2], multu_p [2];
	side_c_t sc_s4, sc_d;

	assign multu_a[0] = co_s4;
	assign multu_b[0] = ccn_s4;
	assign multu_a[1] = omc_s4;
	assign multu_b[1] = six_s4;

	always_comb begin
		sc_s4.ccn   = ccn_s4;
		sc_s4.gamma = gamma_s4;
		sc_s4.co    = co_s4;
		sc_s4.cc    = cc_s4;
		sc_s4.cd    = cd_s4;
		sc_s4.inr   = inr_s4;
	end

	cicfv_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_mul_uq (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s4),
		.a(multu_a), .b(multu_b), .vout(vtu), .p(multu_p)
	);

	cicfv_delay #(.WIDTH($bits(side_c_t)), .DEPTH(MUL_DEPTH)) u_dl_c (
		.clk(clk), .en(en), .din(sc_s4), .dout(sc_d)
	);

	// stage 5: quickest sum, hyper-c divider operands
	logic        v_s5;
	logic [63:0] dbn_s5 [1], dbd_s5 [1];
	logic [0:0]  dbneg_s5;
	side_d_t     sd_s5;
	val_t        t2, t4, t8, tu;

	always_comb begin
		t2 = cicfv_pkg::add_s(multu_p[0], multu_p[0]);
		t4 = cicfv_pkg::add_s(t2, t2);
		t8 = cicfv_pkg::add_s(t4, t4);
		tu = cicfv_pkg::add_s(t8, multu_p[1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= vtu;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dbn_s5[0]   <= cicfv_pkg::mag(sc_d.ccn);
			dbd_s5[0]   <= cicfv_pkg::mag(sc_d.co);
			dbneg_s5[0] <= sc_d.ccn[63] ^ sc_d.co[63];
			sd_s5.sum   <= (tu + (tu[63] ? 64'sd7 : 64'sd0)) >>> 3;
			sd_s5.ccn   <= sc_d.ccn;
			sd_s5.gamma <= sc_d.gamma;
			sd_s5.cc    <= sc_d.cc;
			sd_s5.cd    <= sc_d.cd;
			sd_s5.inr   <= sc_d.inr;
		end
	end

	logic    vdb;
	val_t    db_q [1];
	side_d_t sd_d;

	cicfv_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div_hc (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s5),
		.num(dbn_s5), .den(dbd_s5), .neg(dbneg_s5), .vout(vdb), .quo(db_q)
	);

	cicfv_delay #(.WIDTH($bits(side_d_t)), .DEPTH(DIV_DEPTH)) u_dl_d (
		.clk(clk), .en(en), .din(sd_s5), .dout(sd_d)
	);

	// stage 6: hyper-c and quickest values
	logic v_s6;
	val_t cjh_s6, cju_s6, gamma_s6, omg_s6, ccn_s6, cc_s6, cd_s6;
	logic inr_s6;
	val_t cjh_c;

	always_comb begin
		if (sd_d.inr)
			cjh_c = (db_q[0] > ONE) ? ONE : db_q[0];
		else
			cjh_c = sd_d.ccn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= vdb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cjh_s6   <= cjh_c;
			if (sd_d.inr)
				cju_s6 <= (sd_d.sum < cjh_c) ? sd_d.sum : cjh_c;
			else
				cju_s6 <= sd_d.ccn;
			gamma_s6 <= sd_d.gamma;
			omg_s6   <= cicfv_pkg::sub_s(ONE, sd_d.gamma);
			ccn_s6   <= sd_d.ccn;
			cc_s6    <= sd_d.cc;
			cd_s6    <= sd_d.cd;
			inr_s6   <= sd_d.inr;
		end
	end

	logic    vcd;
	val_t    mulb_a [2], mulb_b [2], mulb_p [2];
	side_e_t se_s6, se_d;

	assign mulb_a[0] = cjh_s6;
	assign mulb_b[0] = gamma_s6;
	assign mulb_a[1] = cju_s6;
	assign mulb_b[1] = omg_s6;

	always_comb begin
		se_s6.ccn = ccn_s6;
		se_s6.cc  = cc_s6;
		se_s6.cd  = cd_s6;
	end

	cicfv_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_mul_blend (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s6),
		.a(mulb_a), .b(mulb_b), .vout(vcd), .p(mulb_p)
	);

	cicfv_delay #(.WIDTH($bits(side_e_t)), .DEPTH(MUL_DEPTH)) u_dl_e (
		.clk(clk), .en(en), .din(se_s6), .dout(se_d)
	);

	// stage 7: beta divider operands
	logic        v_s7;
	logic [63:0] dcn_s7 [1], dcd_s7 [1];
	logic [0:0]  dcneg_s7;
	side_f_t     sf_s7;
	val_t        cjss, bnum, bden;

	always_comb begin
		cjss = cicfv_pkg::add_s(mulb_p[0], mulb_p[1]);
		bnum = cicfv_pkg::sub_s(cjss, se_d.ccn);
		bden = cicfv_pkg::sub_s(ONE, se_d.ccn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= vcd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dcn_s7[0]   <= cicfv_pkg::mag(bnum);
			dcd_s7[0]   <= cicfv_pkg::mag(bden);
			dcneg_s7[0] <= bnum[63] ^ bden[63];
			sf_s7.cc    <= se_d.cc;
			sf_s7.cd    <= se_d.cd;
		end
	end

	logic    vdc;
	val_t    dc_q [1];
	side_f_t sf_d;

	cicfv_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div_beta (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s7),
		.num(dcn_s7), .den(dcd_s7), .neg(dcneg_s7), .vout(vdc), .quo(dc_q)
	);

	cicfv_delay #(.WIDTH($bits(side_f_t)), .DEPTH(DIV_DEPTH)) u_dl_f (
		.clk(clk), .en(en), .din(sf_s7), .dout(sf_d)
	);

	// stage 8: beta weights
	logic v_s8;
	val_t beta_s8, omb_s8, cc_s8, cd_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= vdc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beta_s8 <= dc_q[0];
			omb_s8  <= cicfv_pkg::sub_s(ONE, dc_q[0]);
			cc_s8   <= sf_d.cc;
			cd_s8   <= sf_d.cd;
		end
	end

	logic ve;
	val_t mulc_a [2], mulc_b [2], mulc_p [2];

	assign mulc_a[0] = omb_s8;
	assign mulc_b[0] = cc_s8;
	assign mulc_a[1] = beta_s8;
	assign mulc_b[1] = cd_s8;

	cicfv_mul #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_mul_face (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s8),
		.a(mulc_a), .b(mulc_b), .vout(ve), .p(mulc_p)
	);

	// stage 9: face value with saturation to the sample range
	logic                           v_s9;
	logic signed [SAMPLE_WIDTH-1:0] cj_s9;
	val_t                           cj, cj_sat;

	always_comb begin
		cj = cicfv_pkg::add_s(mulc_p[0], mulc_p[1]);
		if (cj > SMAX)
			cj_sat = SMAX;
		else if (cj < SMIN)
			cj_sat = SMIN;
		else
			cj_sat = cj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= ve;
	end

	always_ff @(posedge clk) begin
		if (en)
			cj_s9 <= cj_sat[SAMPLE_WIDTH-1:0];
	end

	// output register and skid stage
	logic push;

	assign push = v_s9 && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ch.ready || !out_v_q) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ch.ready || !out_v_q)
			out_d_q <= skid_v_q ? skid_d_q : cj_s9;
		else if (push)
			skid_d_q <= cj_s9;
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.face_value = out_d_q;

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds a result while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ch.ready))
		else $error("skid stage filled without an output stall");

	a_gamma_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (!gamma_s4[63] && gamma_s4 <= ONE))
		else $error("gamma outside [0, 1]");

	a_hyperc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && inr_s6) |-> (!cjh_s6[63] && cjh_s6 <= ONE))
		else $error("hyper-c value outside [0, 1]");

endmodule

`default_nettype wire

>>> rtl/core/cicfv_delay.sv
// ----------------------------------------------------------------------------
// cicfv_delay
// stallable delay line that carries side data alongside an arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

module cicfv_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] dl_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= din;
			for (int i = 1; i < DEPTH; i++)
				dl_s[i] <= dl_s[i-1];
		end
	end

	assign dout = dl_s[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/core/cicfv_mul.sv
// ----------------------------------------------------------------------------
// cicfv_mul
// three-stage saturating fixed-point multiplier, sign-magnitude, per lane
// ----------------------------------------------------------------------------
`default_nettype none

module cicfv_mul #(
	parameter int FRAC_BITS = cicfv_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  cicfv_pkg::val_t      a [LANES],
	input  cicfv_pkg::val_t      b [LANES],
	output logic                 vout,
	output cicfv_pkg::val_t      p [LANES]
);

	logic v_s1, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vout <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			vout <= v_s2;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_ln
		logic [63:0]  ma, mb;
		logic [63:0]  pp_s1 [4];
		logic         neg_s1, neg_s2;
		logic [127:0] prod_s2;
		logic         over;
		logic [63:0]  r;
		cicfv_pkg::val_t rs;

		assign ma = cicfv_pkg::mag(a[l]);
		assign mb = cicfv_pkg::mag(b[l]);

		always_ff @(posedge clk) begin
			if (en) begin
				pp_s1[0] <= {32'b0, ma[31:0]} * {32'b0, mb[31:0]};
				pp_s1[1] <= {32'b0, ma[31:0]} * {32'b0, mb[63:32]};
				pp_s1[2] <= {32'b0, ma[63:32]} * {32'b0, mb[31:0]};
				pp_s1[3] <= {32'b0, ma[63:32]} * {32'b0, mb[63:32]};
				neg_s1   <= a[l][63] ^ b[l][63];
				prod_s2  <= {64'b0, pp_s1[0]} + ({64'b0, pp_s1[1]} << 32)
					+ ({64'b0, pp_s1[2]} << 32) + {pp_s1[3], 64'b0};
				neg_s2   <= neg_s1;
			end
		end

		always_comb begin
			over = |prod_s2[127:64+FRAC_BITS];
			r    = prod_s2[63+FRAC_BITS:FRAC_BITS];
			if (over || r > cicfv_pkg::IMAX[63:0])
				r = cicfv_pkg::IMAX[63:0];
			rs = cicfv_pkg::val_t'(r);
		end

		always_ff @(posedge clk) begin
			if (en)
				p[l] <= neg_s2 ? -rs : rs;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cicfv_div.sv
// ----------------------------------------------------------------------------
// cicfv_div
// pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
`default_nettype none

module cicfv_div #(
	parameter int FRAC_BITS = cicfv_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vin,
	input  wire logic [63:0]      num [LANES],
	input  wire logic [63:0]      den [LANES],
	input  wire logic [LANES-1:0] neg,
	output logic                  vout,
	output cicfv_pkg::val_t       quo [LANES]
);

	localparam int NB = 64 + FRAC_BITS;

	logic [NB-1:0] v_s;
	logic [NB-1:0] nb_s  [LANES][NB];
	logic [NB-1:0] q_s   [LANES][NB];
	logic [63:0]   rem_s [LANES][NB];
	logic [63:0]   den_s [LANES][NB];
	logic          neg_s [LANES][NB];

	for (genvar i = 0; i < NB; i++) begin : g_st
		logic v_prev;
		if (i == 0) begin : g_head
			assign v_prev = vin;
		end else begin : g_body
			assign v_prev = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_prev;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_ln
			logic [NB-1:0] nb_prev, q_prev;
			logic [63:0]   rem_prev, den_prev;
			logic          neg_prev;
			logic [64:0]   trial, diff;
			logic          fit;

			if (i == 0) begin : g_head
				assign nb_prev  = {num[l], {FRAC_BITS{1'b0}}};
				assign q_prev   = '0;
				assign rem_prev = '0;
				assign den_prev = den[l];
				assign neg_prev = neg[l];
			end else begin : g_body
				assign nb_prev  = nb_s[l][i-1];
				assign q_prev   = q_s[l][i-1];
				assign rem_prev = rem_s[l][i-1];
				assign den_prev = den_s[l][i-1];
				assign neg_prev = neg_s[l][i-1];
			end

			always_comb begin
				trial = {rem_prev, nb_prev[NB-1]};
				diff  = trial - {1'b0, den_prev};
				fit   = trial >= {1'b0, den_prev};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[l][i] <= fit ? diff[63:0] : trial[63:0];
					nb_s[l][i]  <= {nb_prev[NB-2:0], 1'b0};
					q_s[l][i]   <= {q_prev[NB-2:0], fit};
					den_s[l][i] <= den_prev;
					neg_s[l][i] <= neg_prev;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else if (en)
			vout <= v_s[NB-1];
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		logic [63:0]     r;
		cicfv_pkg::val_t rs;

		always_comb begin
			if (den_s[l][NB-1] == 64'd0)
				r = 64'd0;
			else if (q_s[l][NB-1] > {{(NB-64){1'b0}}, cicfv_pkg::IMAX[63:0]})
				r = cicfv_pkg::IMAX[63:0];
			else
				r = q_s[l][NB-1][63:0];
			rs = cicfv_pkg::val_t'(r);
		end

		always_ff @(posedge clk) begin
			if (en)
				quo[l] <= neg_s[l][NB-1] ? -rs : rs;
		end
	end

endmodule

`default_nettype wire
